// File: rtl/assert_macros.svh
// Assertion helpers included by the blur unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define GBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also evaluated through reset
`define GBB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBB_ASSERT(lbl, clk, rstn, prop, msg)
`define GBB_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/gbb_pkg.sv
`default_nettype none
package gbb_pkg;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int COEF_BITS  = 16;

  localparam int WIN        = 2 * MAX_RADIUS + 1;   // window size, also rows kept
  localparam int SLOT_W     = $clog2(WIN);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 12;
  localparam int RAD_W      = 2;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 24;
  localparam int PROD_W     = 8 + COEF_BITS;
  localparam int RSUM_W     = PROD_W + $clog2(WIN);
  localparam int SUM_W      = RSUM_W + $clog2(WIN);
  localparam int FRAC       = COEF_BITS - 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_COEF0  = 3'd3,
    CFG_COEF1  = 3'd4,
    CFG_COEF2  = 3'd5,
    CFG_COEF3  = 3'd6
  } cfg_addr_t;

  typedef logic [PIX_W-1:0]            pix_t;     // {red, green, blue}
  typedef logic [WIN-1:0][PIX_W-1:0]   col_word_t; // one column, one pixel per row slot
  typedef col_word_t [WIN-1:0]         window_t;  // index 0 is newest column
  typedef logic [3:0][CFG_DATA_W-1:0]  coef_set_t;

  // sideband of one pixel word in the pipe
  typedef struct packed {
    pix_t              pix;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              interior;
    logic              border;
  } item_t;

  // coefficient for |dy|, |dx|
  function automatic logic [COEF_BITS-1:0] coef_at(coef_set_t c, logic [1:0] ady,
                                                   logic [1:0] adx);
    logic [15:0] raw;
    raw = c[ady][16*adx +: 16];
    return raw[COEF_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/gaussian_blur_bgra_unit.sv
`default_nettype none
// Streaming Gaussian blur of a raster-order BGR stream, one pixel word accepted per clock
// while out_ready holds. Pixels within blur_radius of a border come out unchanged; an
// interior pixel comes out when the pixel radius columns right and rows below arrives,
// ahead of that pixel's own pass-through if it has one. The pipe is five stages deep:
// column-store read, window shift, products, row sums, output. Throughput is one word
// per clock, set by the single read-modify-write per column of the column store (1024 x
// 168 bits); a word with two results holds the output and the input until both are
// taken. The store is not cleared after reset. Alpha is always 255. Write configuration
// only while the block is idle; width and height must exceed twice the radius.
module gaussian_blur_bgra_unit import gbb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_blue,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_red,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_alpha,
  output logic [COL_W-1:0]           out_col,
  output logic [ROW_W-1:0]           out_row,
  output logic                       run_last
);
  // configuration
  logic [WCFG_W-1:0] frame_w_r;
  logic [HCFG_W-1:0] frame_h_r;
  logic [RAD_W-1:0]  radius_r;
  coef_set_t         coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= WCFG_W'(640);
      frame_h_r <= HCFG_W'(480);
      radius_r  <= RAD_W'(1);
      coef_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:  frame_w_r <= cfg_data[WCFG_W-1:0];
        CFG_HEIGHT: frame_h_r <= cfg_data[HCFG_W-1:0];
        CFG_RADIUS: radius_r  <= cfg_data[RAD_W-1:0];
        CFG_COEF0:  coef_r[0] <= cfg_data;
        CFG_COEF1:  coef_r[1] <= cfg_data;
        CFG_COEF2:  coef_r[2] <= cfg_data;
        CFG_COEF3:  coef_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;
  logic [RAD_W-1:0]  r_eff;
  assign w_eff = (frame_w_r == '0) ? WCFG_W'(1) :
                 (frame_w_r > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : frame_w_r;
  assign h_eff = (frame_h_r == '0) ? HCFG_W'(1) : frame_h_r;
  assign r_eff = (32'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_r;

  // pipe control: everything moves together when the output stage frees up
  logic adv, accept;
  logic fin_valid_r, fin_int_r, fin_bord_r, phase_r;
  logic take, done;
  assign take     = out_valid && out_ready;
  assign done     = take && run_last;
  assign adv      = !fin_valid_r || done;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // raster position
  logic [COL_W-1:0]  col_count_r;
  logic [ROW_W-1:0]  row_count_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WCFG_W-1:0] col_x;
  logic [ROW_W:0]    row_x;
  logic [WCFG_W-1:0] r_w, r2_w;
  logic [ROW_W:0]    r_h, r2_h;
  logic              row_wrap;

  assign col_x = WCFG_W'(col_count_r);
  assign row_x = (ROW_W+1)'(row_count_r);
  assign r_w   = WCFG_W'(r_eff);
  assign r2_w  = WCFG_W'({r_eff, 1'b0});
  assign r_h   = (ROW_W+1)'(r_eff);
  assign r2_h  = (ROW_W+1)'({r_eff, 1'b0});
  assign row_wrap = (row_x + 1'b1) >= (ROW_W+1)'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      slot_r      <= '0;
    end else if (accept) begin
      if ((col_x + 1'b1) >= w_eff) begin
        col_count_r <= '0;
        if (row_wrap) begin
          row_count_r <= '0;
          slot_r      <= '0;
        end else begin
          row_count_r <= row_count_r + 1'b1;
          slot_r      <= (slot_r == SLOT_W'(WIN-1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_count_r <= col_count_r + 1'b1;
      end
    end
  end

  item_t in_item;
  always_comb begin
    in_item.pix  = {in_red, in_green, in_blue};
    in_item.col  = col_count_r;
    in_item.row  = row_count_r;
    in_item.slot = slot_r;
    in_item.interior = (col_x >= r2_w) && (row_x >= r2_h) &&
                       (col_x < w_eff) && (row_x < (ROW_W+1)'(h_eff));
    in_item.border   = (col_x < r_w) || ((col_x + r_w) >= w_eff) || (row_x < r_h) ||
                       ((row_x + r_h) >= (ROW_W+1)'(h_eff));
  end

  // stage 1: column word read back, merged with the new pixel
  item_t s1_r, s2_r, s3_r, s4_r;
  logic  s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic  s1_fwd_r;
  col_word_t rd_word, last_wr_r, merged;
  logic [WIN*PIX_W-1:0] rd_data;
  logic wr_en;

  assign wr_en = adv && s1_valid_r;

  gbb_line_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_r.col),
    .wr_data (merged)
  );

  always_comb begin
    rd_word = s1_fwd_r ? last_wr_r : col_word_t'(rd_data);
    merged  = rd_word;
    merged[s1_r.slot] = s1_r.pix;
  end

  // window: shift line of column words
  window_t win_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_r <= merged;
      win_r[0]  <= merged;
      for (int k = 1; k < WIN; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
      s1_fwd_r   <= s1_valid_r && (s1_r.col == col_count_r);
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_item;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  pix_t blur;
  gbb_mac u_mac (
    .clk    (clk),
    .en     (adv),
    .win    (win_r),
    .slot   (s2_r.slot),
    .radius (r_eff),
    .coefs  (coef_r),
    .result (blur)
  );

  // output stage: interior result first, then pass-through
  pix_t             fin_blur_r, fin_pix_r;
  logic [COL_W-1:0] fin_col_r, fin_icol_r;
  logic [ROW_W-1:0] fin_row_r, fin_irow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      fin_int_r   <= 1'b0;
      fin_bord_r  <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (adv) begin
        fin_valid_r <= s4_valid_r && (s4_r.interior || s4_r.border);
        fin_int_r   <= s4_r.interior;
        fin_bord_r  <= s4_r.border;
      end
      if (done) begin
        phase_r <= 1'b0;
      end else if (take) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_blur_r <= blur;
      fin_pix_r  <= s4_r.pix;
      fin_col_r  <= s4_r.col;
      fin_row_r  <= s4_r.row;
      fin_icol_r <= s4_r.col - COL_W'(r_eff);
      fin_irow_r <= s4_r.row - ROW_W'(r_eff);
    end
  end

  logic show_int;
  assign show_int  = fin_int_r && !phase_r;
  assign out_valid = fin_valid_r;
  assign run_last  = phase_r || !(fin_int_r && fin_bord_r);
  assign out_blue  = show_int ? fin_blur_r[7:0]   : fin_pix_r[7:0];
  assign out_green = show_int ? fin_blur_r[15:8]  : fin_pix_r[15:8];
  assign out_red   = show_int ? fin_blur_r[23:16] : fin_pix_r[23:16];
  assign out_alpha = 8'd255;
  assign out_col   = show_int ? fin_icol_r : fin_col_r;
  assign out_row   = show_int ? fin_irow_r : fin_row_r;

`include "assert_macros.svh"
  `GBB_ASSERT(a_phase_pair, clk, rst_n, phase_r |-> (fin_valid_r && fin_int_r && fin_bord_r), "second result without a pair")
  `GBB_ASSERT(a_fin_has_result, clk, rst_n, fin_valid_r |-> (fin_int_r || fin_bord_r), "output word with no result")
  `GBB_ASSERT(a_fwd_same_col, clk, rst_n, (accept && s1_valid_r && (s1_r.col == col_count_r)) |=> s1_fwd_r, "missed column forward")
  `GBB_ASSERT(a_ready_when_free, clk, rst_n, !fin_valid_r |-> in_ready, "stall with empty output")
  `GBB_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid after reset")
endmodule
`default_nettype wire

// File: rtl/gbb_line_mem.sv
`default_nettype none
// Column store: one word per column, one pixel slot per kept row.
module gbb_line_mem import gbb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [WIN*PIX_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [WIN*PIX_W-1:0] wr_data
);
  logic [WIN*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/gbb_mac.sv
`default_nettype none
// Window multiply-accumulate: products, row sums, then total with saturation.
module gbb_mac import gbb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire window_t           win,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [RAD_W-1:0]  radius,
  input  wire coef_set_t         coefs,
  output pix_t                   result
);
  logic [PROD_W-1:0] prod_nxt [WIN][WIN][3];
  logic [PROD_W-1:0] prod_r   [WIN][WIN][3];
  logic [RSUM_W-1:0] rsum_nxt [WIN][3];
  logic [RSUM_W-1:0] rsum_r   [WIN][3];

  // products; rows by age d, columns by age k; taps outside the kernel are
  // forced to zero so rows and columns not yet written never reach the sum
  always_comb begin
    logic [SLOT_W:0]     s;
    logic [2:0]          ady, adx;
    logic [COEF_BITS-1:0] c;
    pix_t                p;
    logic                in_k;
    for (int d = 0; d < WIN; d++) begin
      for (int k = 0; k < WIN; k++) begin
        s = {1'b0, slot} + (SLOT_W+1)'(WIN) - (SLOT_W+1)'(d);
        if (s >= (SLOT_W+1)'(WIN)) s = s - (SLOT_W+1)'(WIN);
        ady = (3'(d) >= 3'(radius)) ? 3'(d) - 3'(radius) : 3'(radius) - 3'(d);
        adx = (3'(k) >= 3'(radius)) ? 3'(k) - 3'(radius) : 3'(radius) - 3'(k);
        p = win[k][s[SLOT_W-1:0]];
        in_k = (4'(d) <= 4'({radius, 1'b0})) && (4'(k) <= 4'({radius, 1'b0}));
        c = coef_at(coefs, ady[1:0], adx[1:0]);
        for (int ch = 0; ch < 3; ch++) begin
          prod_nxt[d][k][ch] = in_k ? PROD_W'(p[8*ch +: 8]) * PROD_W'(c) : '0;
        end
      end
    end
  end

  // one row of seven products per lane
  always_comb begin
    for (int d = 0; d < WIN; d++) begin
      for (int ch = 0; ch < 3; ch++) begin
        rsum_nxt[d][ch] = '0;
        for (int k = 0; k < WIN; k++) begin
          rsum_nxt[d][ch] = rsum_nxt[d][ch] + RSUM_W'(prod_r[d][k][ch]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      rsum_r <= rsum_nxt;
    end
  end

  // total, drop fraction, clamp at 255
  always_comb begin
    logic [SUM_W-1:0] tot;
    logic [SUM_W-1:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      tot = '0;
      for (int d = 0; d < WIN; d++) begin
        tot = tot + SUM_W'(rsum_r[d][ch]);
      end
      v = tot >> FRAC;
      result[8*ch +: 8] = (v > SUM_W'(255)) ? 8'd255 : v[7:0];
    end
  end
endmodule
`default_nettype wire
